### rtl/rmv_pkg.sv
package rmv_pkg;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_MERGE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] sample;
        logic [31:0]        other_count;
        logic signed [31:0] other_mean;
        logic [63:0]        other_sq_dev;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        total_count;
        logic signed [31:0] running_mean;
        logic [63:0]        variance;
        logic [31:0]        sigma;
        logic [31:0]        std_error;
        logic               saturated;
    } t_out_item;

endpackage

### rtl/running_mean_variance.sv
// a restoring divider, a shift-add multiplier and a square root unit, one bit per cycle each,
// are used in turn by a sequencer; a new transaction is taken only in the idle state, so one
// transaction is finished before the next is accepted, and a stalled result holds the next
// transaction only at its last step. synchronous active-low reset clears all statistics
module running_mean_variance
    import rmv_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int MW = (COUNT_BITS > 32) ? COUNT_BITS : 32;
    localparam int DW = MW + 1;
    localparam int NW = 64 + COUNT_BITS + 32;
    localparam int KW = $clog2(NW + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_ADD_DIV  = 5'd1;
    localparam logic [4:0] S_ADD_MEAN = 5'd2;
    localparam logic [4:0] S_ADD_MUL  = 5'd3;
    localparam logic [4:0] S_ADD_ACC  = 5'd4;
    localparam logic [4:0] S_MRG_PRE  = 5'd5;
    localparam logic [4:0] S_MRG_DIV1 = 5'd6;
    localparam logic [4:0] S_MRG_STEP = 5'd7;
    localparam logic [4:0] S_MRG_MUL1 = 5'd8;
    localparam logic [4:0] S_MRG_MUL2 = 5'd9;
    localparam logic [4:0] S_MRG_DIV2 = 5'd10;
    localparam logic [4:0] S_MRG_FIN  = 5'd11;
    localparam logic [4:0] S_STAT     = 5'd12;
    localparam logic [4:0] S_VAR_DIV  = 5'd13;
    localparam logic [4:0] S_SE_DIV   = 5'd14;
    localparam logic [4:0] S_SQ_SE    = 5'd15;
    localparam logic [4:0] S_SQ_SIG   = 5'd16;
    localparam logic [4:0] S_FIN      = 5'd17;

    logic [4:0]             r_state, n_state;
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic signed [31:0]     r_mean, n_mean;
    logic [63:0]            r_sq, n_sq;
    logic                   r_sat, n_sat;
    logic                   r_ovalid, n_ovalid;

    logic [31:0]            r_mag, n_mag;
    logic                   r_neg, n_neg;
    logic signed [31:0]     r_x, n_x;
    logic [31:0]            r_oc, n_oc;
    logic [DW-1:0]          r_total, n_total;
    logic [NW-1:0]          r_num, n_num;
    logic [DW-1:0]          r_rem, n_rem;
    logic [DW-1:0]          r_dvs, n_dvs;
    logic [NW-1:0]          r_mcand, n_mcand;
    logic [MW-1:0]          r_mplier, n_mplier;
    logic [KW-1:0]          r_cnt, n_cnt;
    logic [63:0]            r_var, n_var;
    logic [63:0]            r_sqv, n_sqv;
    logic [33:0]            r_sqrem, n_sqrem;
    logic [31:0]            r_root, n_root;
    logic [31:0]            r_se, n_se;
    t_out_item              r_out, n_out;

    logic                   accept;
    logic signed [32:0]     a_delta, m_delta, x_delta;
    logic [32:0]            a_abs, m_abs, x_abs;
    logic [COUNT_BITS-1:0]  a_n;
    logic [DW-1:0]          m_total;
    logic [64:0]            in_sum, fin_sum;
    logic                   over;
    logic [63:0]            term;

    logic [31:0]            mul_a, mul_b;
    logic [63:0]            mul_p;

    logic [DW:0]            d_sh, d_dif;
    logic                   d_ge;
    logic [DW-1:0]          d_rem_nx;
    logic [NW-1:0]          d_num_nx;
    logic [NW-1:0]          m_num_nx;
    logic [33:0]            s_sh, s_tr, s_dif;
    logic                   s_ge;
    logic [31:0]            step;
    logic signed [31:0]     mean_step;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    // input-side differences and sums
    assign a_delta = {i_item.sample[31], i_item.sample} - {r_mean[31], r_mean};
    assign a_abs   = a_delta[32] ? 33'(-a_delta) : 33'(a_delta);
    assign m_delta = {i_item.other_mean[31], i_item.other_mean} - {r_mean[31], r_mean};
    assign m_abs   = m_delta[32] ? 33'(-m_delta) : 33'(m_delta);
    assign a_n     = (r_count == CMAX) ? r_count : r_count + 1'b1;
    assign m_total = DW'(r_count) + DW'(i_item.other_count);
    assign in_sum  = {1'b0, r_sq} + {1'b0, i_item.other_sq_dev};

    assign x_delta = {r_x[31], r_x} - {r_mean[31], r_mean};
    assign x_abs   = x_delta[32] ? 33'(-x_delta) : 33'(x_delta);

    // merge squared term
    assign over    = |r_num[NW-1:64];
    assign term    = over ? '1 : r_num[63:0];
    assign fin_sum = {1'b0, r_sq} + {1'b0, term};

    // shared multiplier
    always_comb begin
        case (r_state)
            S_MRG_PRE: begin
                mul_a = r_mag;
                mul_b = r_oc;
            end
            S_ADD_MUL: begin
                mul_a = r_mag;
                mul_b = x_abs[31:0];
            end
            default: begin
                mul_a = r_mag;
                mul_b = r_mag;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // restoring divider step
    assign d_sh     = {r_rem, r_num[NW-1]};
    assign d_dif    = d_sh - {1'b0, r_dvs};
    assign d_ge     = (d_sh >= {1'b0, r_dvs});
    assign d_rem_nx = d_ge ? d_dif[DW-1:0] : d_sh[DW-1:0];
    assign d_num_nx = {r_num[NW-2:0], d_ge};

    // shift-add multiplier step
    assign m_num_nx = {r_num[NW-2:0], 1'b0} + (r_mplier[MW-1] ? r_mcand : '0);

    // square root step
    assign s_sh  = {r_sqrem[31:0], r_sqv[63:62]};
    assign s_tr  = {r_root, 2'b01};
    assign s_dif = s_sh - s_tr;
    assign s_ge  = (s_sh >= s_tr);

    assign step      = r_num[31:0];
    assign mean_step = r_neg ? r_mean - $signed(step) : r_mean + $signed(step);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_mean   = r_mean;
        n_sq     = r_sq;
        n_sat    = r_sat;
        n_ovalid = r_ovalid && i_stall;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_x      = r_x;
        n_oc     = r_oc;
        n_total  = r_total;
        n_num    = r_num;
        n_rem    = r_rem;
        n_dvs    = r_dvs;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        n_var    = r_var;
        n_sqv    = r_sqv;
        n_sqrem  = r_sqrem;
        n_root   = r_root;
        n_se     = r_se;
        n_out    = r_out;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_STAT;
                    case (i_item.operation)
                        OP_ADD: begin
                            n_count = a_n;
                            n_sat   = r_sat | (r_count == CMAX);
                            n_mag   = a_abs[31:0];
                            n_neg   = a_delta[32];
                            n_x     = i_item.sample;
                            n_num   = NW'(a_abs[31:0]) << (NW - 32);
                            n_rem   = '0;
                            n_dvs   = DW'(a_n);
                            n_cnt   = KW'(32);
                            n_state = S_ADD_DIV;
                        end
                        OP_MERGE: begin
                            if (i_item.other_count == '0) begin
                                n_state = S_STAT;
                            end else if (r_count == '0) begin
                                if (DW'(i_item.other_count) > DW'(CMAX)) begin
                                    n_count = CMAX;
                                    n_sat   = 1'b1;
                                end else begin
                                    n_count = COUNT_BITS'(i_item.other_count);
                                end
                                n_mean = i_item.other_mean;
                                n_sq   = i_item.other_sq_dev;
                            end else begin
                                n_mag   = m_abs[31:0];
                                n_neg   = m_delta[32];
                                n_oc    = i_item.other_count;
                                n_total = m_total;
                                n_sq    = in_sum[64] ? '1 : in_sum[63:0];
                                n_sat   = r_sat | in_sum[64];
                                n_state = S_MRG_PRE;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_mean  = '0;
                            n_sq    = '0;
                            n_sat   = 1'b0;
                        end
                        default: begin
                            n_state = S_STAT;
                        end
                    endcase
                end
            end
            S_ADD_DIV: begin
                if (r_cnt != '0) begin
                    n_num = d_num_nx;
                    n_rem = d_rem_nx;
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_state = S_ADD_MEAN;
                end
            end
            S_ADD_MEAN: begin
                n_mean  = mean_step;
                n_state = S_ADD_MUL;
            end
            S_ADD_MUL: begin
                n_mcand = NW'(mul_p);
                n_state = S_ADD_ACC;
            end
            S_ADD_ACC: begin
                n_sq[63:0] = (({1'b0, r_sq} + {1'b0, r_mcand[63:0]}) > 65'h0_FFFF_FFFF_FFFF_FFFF)
                             ? '1 : r_sq + r_mcand[63:0];
                n_sat   = r_sat | (({1'b0, r_sq} + {1'b0, r_mcand[63:0]}) > 65'h0_FFFF_FFFF_FFFF_FFFF);
                n_state = S_STAT;
            end
            S_MRG_PRE: begin
                n_num   = NW'(mul_p) << (NW - 64);
                n_rem   = '0;
                n_dvs   = r_total;
                n_cnt   = KW'(64);
                n_state = S_MRG_DIV1;
            end
            S_MRG_DIV1: begin
                if (r_cnt != '0) begin
                    n_num = d_num_nx;
                    n_rem = d_rem_nx;
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_state = S_MRG_STEP;
                end
            end
            S_MRG_STEP: begin
                n_mean   = mean_step;
                n_mcand  = NW'(mul_p);
                n_num    = '0;
                n_mplier = MW'(r_count);
                n_cnt    = KW'(MW);
                n_state  = S_MRG_MUL1;
            end
            S_MRG_MUL1: begin
                if (r_cnt != '0) begin
                    n_num    = m_num_nx;
                    n_mplier = {r_mplier[MW-2:0], 1'b0};
                    n_cnt    = r_cnt - 1'b1;
                end else begin
                    n_mcand  = r_num;
                    n_num    = '0;
                    n_mplier = MW'(r_oc);
                    n_cnt    = KW'(MW);
                    n_state  = S_MRG_MUL2;
                end
            end
            S_MRG_MUL2: begin
                if (r_cnt != '0) begin
                    n_num    = m_num_nx;
                    n_mplier = {r_mplier[MW-2:0], 1'b0};
                    n_cnt    = r_cnt - 1'b1;
                end else begin
                    n_rem   = '0;
                    n_dvs   = r_total;
                    n_cnt   = KW'(NW);
                    n_state = S_MRG_DIV2;
                end
            end
            S_MRG_DIV2: begin
                if (r_cnt != '0) begin
                    n_num = d_num_nx;
                    n_rem = d_rem_nx;
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_state = S_MRG_FIN;
                end
            end
            S_MRG_FIN: begin
                n_sq  = fin_sum[64] ? '1 : fin_sum[63:0];
                n_sat = r_sat | over | fin_sum[64];
                if (r_total > DW'(CMAX)) begin
                    n_count = CMAX;
                    n_sat   = 1'b1;
                end else begin
                    n_count = r_total[COUNT_BITS-1:0];
                end
                n_state = S_STAT;
            end
            S_STAT: begin
                if (r_count > COUNT_BITS'(1)) begin
                    n_num   = NW'(r_sq) << (NW - 64);
                    n_rem   = '0;
                    n_dvs   = DW'(r_count - 1'b1);
                    n_cnt   = KW'(64);
                    n_state = S_VAR_DIV;
                end else begin
                    n_var   = '0;
                    n_root  = '0;
                    n_se    = '0;
                    n_state = S_FIN;
                end
            end
            S_VAR_DIV: begin
                if (r_cnt != '0) begin
                    n_num = d_num_nx;
                    n_rem = d_rem_nx;
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_var   = r_num[63:0];
                    n_num   = NW'(r_num[63:0]) << (NW - 64);
                    n_rem   = '0;
                    n_dvs   = DW'(r_count);
                    n_cnt   = KW'(64);
                    n_state = S_SE_DIV;
                end
            end
            S_SE_DIV: begin
                if (r_cnt != '0) begin
                    n_num = d_num_nx;
                    n_rem = d_rem_nx;
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_sqv   = r_num[63:0];
                    n_sqrem = '0;
                    n_root  = '0;
                    n_cnt   = KW'(32);
                    n_state = S_SQ_SE;
                end
            end
            S_SQ_SE: begin
                if (r_cnt != '0) begin
                    n_sqv   = {r_sqv[61:0], 2'b00};
                    n_sqrem = s_ge ? s_dif : s_sh;
                    n_root  = {r_root[30:0], s_ge};
                    n_cnt   = r_cnt - 1'b1;
                end else begin
                    n_se    = r_root;
                    n_sqv   = r_var;
                    n_sqrem = '0;
                    n_root  = '0;
                    n_cnt   = KW'(32);
                    n_state = S_SQ_SIG;
                end
            end
            S_SQ_SIG: begin
                if (r_cnt != '0) begin
                    n_sqv   = {r_sqv[61:0], 2'b00};
                    n_sqrem = s_ge ? s_dif : s_sh;
                    n_root  = {r_root[30:0], s_ge};
                    n_cnt   = r_cnt - 1'b1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovalid || !i_stall) begin
                    n_out.total_count  = 32'(r_count);
                    n_out.running_mean = r_mean;
                    n_out.variance     = r_var;
                    n_out.sigma        = r_root;
                    n_out.std_error    = r_se;
                    n_out.saturated    = r_sat;
                    n_ovalid           = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_mean   <= '0;
            r_sq     <= '0;
            r_sat    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_mean   <= n_mean;
            r_sq     <= n_sq;
            r_sat    <= n_sat;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_x      <= n_x;
        r_oc     <= n_oc;
        r_total  <= n_total;
        r_num    <= n_num;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_cnt    <= n_cnt;
        r_var    <= n_var;
        r_sqv    <= n_sqv;
        r_sqrem  <= n_sqrem;
        r_root   <= n_root;
        r_se     <= n_se;
        r_out    <= n_out;
    end

endmodule

### tb/tb_top.sv
module tb_top;
    import rmv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] CNT_MAX = 64'hFFFF_FFFF;
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_item;

    running_mean_variance dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // model state of the statistics
    logic [63:0]        st_count;
    logic signed [63:0] st_mean;
    logic [63:0]        st_m2;
    logic               st_sat;

    t_in_item  pending_items[$];
    t_out_item expected_stats[$];
    int        n_errors = 0;
    int        n_checked = 0;
    int        n_ops[4] = '{0, 0, 0, 0};
    bit        hold_off = 1'b0;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[64]) begin
            st_sat = 1'b1;
            return '1;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] abs64(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_out_item predict_stats(t_in_item it);
        t_out_item r;
        logic [63:0] n, mag, mag2, step, tot, term;
        logic signed [63:0] delta, mnew;
        logic [255:0] prod;
        logic [255:0] quot;
        logic [63:0] var_v, se, sig;
        case (it.operation)
            OP_ADD: begin
                if (st_count < CNT_MAX) begin
                    n = st_count + 1;
                end else begin
                    n = CNT_MAX;
                    st_sat = 1'b1;
                end
                st_count = n;
                delta = 64'(signed'(it.sample)) - st_mean;
                mag = abs64(delta);
                step = mag / n;
                mnew = delta < 0 ? st_mean - step : st_mean + step;
                mag2 = abs64(64'(signed'(it.sample)) - mnew);
                st_mean = mnew;
                st_m2 = sat_sum(st_m2, mag * mag2);
            end
            OP_MERGE: begin
                if (it.other_count != 0) begin
                    if (st_count == 0) begin
                        st_count = it.other_count;
                        st_mean = signed'(it.other_mean);
                        st_m2 = it.other_sq_dev;
                    end else begin
                        tot = st_count + it.other_count;
                        delta = 64'(signed'(it.other_mean)) - st_mean;
                        mag = abs64(delta);
                        step = (mag * it.other_count) / tot;
                        prod = 256'(mag * mag) * 256'(st_count) * 256'(it.other_count);
                        quot = prod / 256'(tot);
                        term = quot[63:0];
                        if (quot[255:64] != 0) begin
                            term = '1;
                            st_sat = 1'b1;
                        end
                        st_mean = delta < 0 ? st_mean - step : st_mean + step;
                        st_m2 = sat_sum(sat_sum(st_m2, it.other_sq_dev), term);
                        if (tot > CNT_MAX) begin
                            tot = CNT_MAX;
                            st_sat = 1'b1;
                        end
                        st_count = tot;
                    end
                end
            end
            OP_CLEAR: begin
                st_count = 0;
                st_mean = 0;
                st_m2 = 0;
                st_sat = 1'b0;
            end
            default: ;
        endcase
        var_v = 0;
        se = 0;
        if (st_count >= 2) begin
            var_v = st_m2 / (st_count - 1);
            se = int_sqrt(var_v / st_count);
        end
        sig = int_sqrt(var_v);
        r.total_count  = st_count[31:0];
        r.running_mean = st_mean[31:0];
        r.variance     = var_v;
        r.sigma        = sig[31:0];
        r.std_error    = se[31:0];
        r.saturated    = st_sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        n_errors++;
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_checked);
    endtask

    task automatic predict_stats_push(t_in_item it);
        expected_stats.push_back(predict_stats(it));
        n_ops[it.operation]++;
    endtask

    function automatic t_in_item mk(logic [1:0] op, logic [31:0] x, logic [31:0] oc,
                                    logic [31:0] om, logic [63:0] m2);
        t_in_item t;
        t.operation = op;
        t.sample = x;
        t.other_count = oc;
        t.other_mean = om;
        t.other_sq_dev = m2;
        return t;
    endfunction

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($urandom_range(0, 2000)) - 32'd1000;
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom())};
            default: return $urandom() & 32'h00FF_FFFF;
        endcase
    endfunction

    function automatic t_in_item rnd_item();
        int k;
        logic [31:0] oc;
        k = $urandom_range(0, 99);
        if (k < 70) return mk(OP_ADD, rnd_val(), $urandom(), $urandom(), {$urandom(), $urandom()});
        if (k < 90) begin
            oc = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 50);
            return mk(OP_MERGE, $urandom(), oc, rnd_val(),
                      $urandom_range(0, 3) == 0 ? {$urandom(), $urandom()}
                                                : 64'($urandom()) << $urandom_range(0, 20));
        end
        if (k < 96) return mk(OP_CLEAR, $urandom(), $urandom(), $urandom(), 64'($urandom()));
        return mk(OP_SPARE, $urandom(), $urandom(), $urandom(), {$urandom(), $urandom()});
    endfunction

    // driver: bursts and gaps
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_stats_push(i_item);
            end
            if (i_valid && o_stall) begin
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_item <= pending_items.pop_front();
                i_valid <= 1'b1;
                if (burst_left <= 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 300);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (hold_off) i_stall <= 1'b1;
        else if (stall_phase % 2000 < 700) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 99) < 40);
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_stats.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_item.total_count), 64'd0);
            end else begin
                want = expected_stats.pop_front();
                if (o_item.total_count != want.total_count)
                    report_mismatch("total_count", 64'(o_item.total_count),
                                    64'(want.total_count));
                if (o_item.running_mean != want.running_mean)
                    report_mismatch("running_mean", 64'(o_item.running_mean),
                                    64'(want.running_mean));
                if (o_item.variance != want.variance)
                    report_mismatch("variance", o_item.variance, want.variance);
                if (o_item.sigma != want.sigma)
                    report_mismatch("sigma", 64'(o_item.sigma), 64'(want.sigma));
                if (o_item.std_error != want.std_error)
                    report_mismatch("std_error", 64'(o_item.std_error), 64'(want.std_error));
                if (o_item.saturated != want.saturated)
                    report_mismatch("saturated", 64'(o_item.saturated), 64'(want.saturated));
            end
            n_checked++;
        end
    end

    initial begin
        st_count = 0;
        st_mean = 0;
        st_m2 = 0;
        st_sat = 1'b0;
        // directed: extremes, every operation, empty-side merges, saturation
        pending_items.push_back(mk(OP_ADD, 32'h7FFF_FFFF, '1, '1, '1));
        pending_items.push_back(mk(OP_ADD, 32'h8000_0000, 0, 0, 0));
        pending_items.push_back(mk(OP_ADD, 32'h0, 0, 0, 0));
        pending_items.push_back(mk(OP_ADD, 32'hFFFF_FFFF, 0, 0, 0));
        pending_items.push_back(mk(OP_MERGE, 0, 0, 32'h1234, 64'h55));
        pending_items.push_back(mk(OP_MERGE, 0, 5, 32'h7FFF_FFFF, '1));
        pending_items.push_back(mk(OP_SPARE, '1, '1, '1, '1));
        pending_items.push_back(mk(OP_CLEAR, '1, '1, '1, '1));
        pending_items.push_back(mk(OP_ADD, 32'h0001_0000, 0, 0, 0));
        pending_items.push_back(mk(OP_MERGE, 0, 32'hFFFF_FFFF, 32'h8000_0000, 64'h1_0000_0000));
        pending_items.push_back(mk(OP_ADD, 32'h7FFF_FFFF, 0, 0, 0));
        pending_items.push_back(mk(OP_CLEAR, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_MERGE, 0, 32'hFFFF_FFFE, 32'h10, 64'h100));
        pending_items.push_back(mk(OP_ADD, 32'h20, 0, 0, 0));
        pending_items.push_back(mk(OP_ADD, 32'h30, 0, 0, 0));
        pending_items.push_back(mk(OP_CLEAR, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_ADD, 32'h0000_8000, 0, 0, 0));
        pending_items.push_back(mk(OP_MERGE, 0, 3, 32'hFFFF_0000, 64'h3_0000_0000));
        pending_items.push_back(mk(OP_MERGE, 0, 1, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_items.push_back(mk(OP_CLEAR, 0, 0, 0, 0));
        for (int i = 0; i < 750; i++) pending_items.push_back(rnd_item());

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // long receiver hold-off while items keep coming
        wait (n_checked >= 40);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_off <= 1'b0;

        wait (pending_items.size() == 0 && !i_valid);
        wait (expected_stats.size() == 0);
        repeat (500) @(posedge i_clk);
        $display("covered %0d results: %0d adds, %0d merges, %0d clears, %0d unused codes",
                 n_checked, n_ops[0], n_ops[1], n_ops[2], n_ops[3]);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("Verification failed");
        $finish;
    end
endmodule
